// File: hw/rtl/fdm_pkg.sv
// shared constants, types and the exp2 factor table for the mobility unit
package fdm_pkg;

    localparam int FIELD_W   = 20;
    localparam int MOB_W     = 20;
    localparam int TIME_W    = 24;
    localparam int RECIP_W   = 32;
    localparam int BETA_W    = 20;
    localparam int THICK_W   = 16;
    localparam int FRAC_W    = 24;
    localparam int MANT_W    = 32;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    localparam logic [MOB_W-1:0]   MOB_MAX  = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX = '1;
    localparam int                 UM_TO_NS_SCALE = 100000;

    localparam logic [MOB_W-1:0]   RST_LOW_FIELD_MOB = 20'd391680;
    localparam logic [RECIP_W-1:0] RST_CRIT_RECIP    = 32'd612250;
    localparam logic [BETA_W-1:0]  RST_BETA          = 20'd72745;
    localparam logic [BETA_W-1:0]  RST_BETA_RECIP    = 20'd59040;
    localparam logic [THICK_W-1:0] RST_THICKNESS     = 16'd500;

    // register index, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_LOW_FIELD_MOB = 3'd0,
        REG_CRIT_RECIP    = 3'd1,
        REG_BETA          = 3'd2,
        REG_BETA_RECIP    = 3'd3,
        REG_THICKNESS     = 3'd4
    } reg_idx_t;

    // range class of the exponent beta * log2(E/Ec)
    typedef enum logic [1:0] {
        CLS_MID   = 2'd0,
        CLS_BIG   = 2'd1,
        CLS_SMALL = 2'd2
    } exp_cls_t;

    typedef logic [FRAC_W:0][MANT_W-1:0] rom_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] xr;
        logic [63:0] res;
        logic [63:0] bitv;
        xr   = x;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bitv > xr) begin
                bitv = bitv >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (bitv != 64'd0) begin
                if (xr >= res + bitv) begin
                    xr  = xr - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // entry k is 2^(2^-k) in Q1.30, each the square root of the one before
    function automatic rom_t build_rom();
        rom_t r;
        r[0] = 32'h8000_0000;
        for (int k = 1; k <= FRAC_W; k++) begin
            r[k] = MANT_W'(isqrt64({32'd0, r[k-1]} << 30));
        end
        return r;
    endfunction

    localparam rom_t EXP2_ROM = build_rom();

endpackage

// File: hw/rtl/field_dependent_mobility_unit.sv
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a finished result waits on m_ready.
// Depth is set by the two log2 units (26 stages each), the two exp2 units
// and the drift-time divider (24 stages each).
// Reset (aresetn, synchronous, active low) empties the pipeline and loads
// the register defaults.
module field_dependent_mobility_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdm_pkg::APB_AW-1:0]    paddr,
    input  logic [fdm_pkg::APB_DW-1:0]    pwdata,
    output logic [fdm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fdm_pkg::FIELD_W-1:0]   s_electric_field,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fdm_pkg::MOB_W-1:0]     m_mobility,
    output logic [fdm_pkg::TIME_W-1:0]    m_drift_time,
    output logic                          m_time_saturated
);
    import fdm_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] e;
        logic               zero;
    } sa_t;

    typedef struct packed {
        logic [FIELD_W-1:0] e;
        logic               zero;
        exp_cls_t           cls;
        logic [6:0]         d;
        logic [33:0]        mag;
    } sb_t;

    typedef struct packed {
        logic [FIELD_W-1:0] e;
        logic               zero;
        exp_cls_t           cls;
        logic [33:0]        mag;
    } sc_t;

    typedef struct packed {
        logic [FIELD_W-1:0] e;
        logic               zero;
        logic               kbig;
        logic [5:0]         ksh;
    } sd_t;

    typedef struct packed {
        logic [MOB_W-1:0] mu;
        logic             sat;
    } se_t;

    // configuration registers
    logic [MOB_W-1:0]   low_mob_reg;
    logic [RECIP_W-1:0] crit_recip_reg;
    logic [BETA_W-1:0]  beta_reg;
    logic [BETA_W-1:0]  beta_recip_reg;
    logic [THICK_W-1:0] thick_reg;
    logic               wr_en;
    reg_idx_t           widx;

    logic en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_mob_reg    <= RST_LOW_FIELD_MOB;
            crit_recip_reg <= RST_CRIT_RECIP;
            beta_reg       <= RST_BETA;
            beta_recip_reg <= RST_BETA_RECIP;
            thick_reg      <= RST_THICKNESS;
        end else if (wr_en) begin
            unique case (widx)
                REG_LOW_FIELD_MOB: low_mob_reg    <= pwdata[MOB_W-1:0];
                REG_CRIT_RECIP:    crit_recip_reg <= pwdata[RECIP_W-1:0];
                REG_BETA:          beta_reg       <= pwdata[BETA_W-1:0];
                REG_BETA_RECIP:    beta_recip_reg <= pwdata[BETA_W-1:0];
                REG_THICKNESS:     thick_reg      <= pwdata[THICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_LOW_FIELD_MOB: prdata = APB_DW'(low_mob_reg);
            REG_CRIT_RECIP:    prdata = APB_DW'(crit_recip_reg);
            REG_BETA:          prdata = APB_DW'(beta_reg);
            REG_BETA_RECIP:    prdata = APB_DW'(beta_recip_reg);
            REG_THICKNESS:     prdata = APB_DW'(thick_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------- stage a: r = E / Ec in Q.32
    logic               a_vld_reg;
    logic [51:0]        a_r_reg;
    logic [FIELD_W-1:0] a_e_reg;
    sa_t                a_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_r_reg <= 52'(s_electric_field) * 52'(crit_recip_reg);
            a_e_reg <= s_electric_field;
        end
    end

    assign a_side.e    = a_e_reg;
    assign a_side.zero = (a_r_reg == '0);

    logic              la_vld;
    logic [5:0]        la_p;
    logic [FRAC_W-1:0] la_frac;
    sa_t               la_side;

    fdm_log2 #(.IN_W(52), .SIDE_W($bits(sa_t))) u_log2_field (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (a_vld_reg),
        .in_x     (a_r_reg),
        .in_side  (a_side),
        .out_vld  (la_vld),
        .out_p    (la_p),
        .out_frac (la_frac),
        .out_side (la_side)
    );

    // ---------------- stage b: |log2(E/Ec)| and its sign
    logic        b_vld_reg;
    logic        b_neg_reg;
    logic [29:0] b_abs_reg;
    sa_t         b_side_reg;
    logic        b_neg_next;
    logic [5:0]  b_int;
    logic [29:0] b_abs_next;

    assign b_neg_next = la_p < 6'd32;
    assign b_int      = b_neg_next ? 6'd32 - la_p : la_p - 6'd32;
    assign b_abs_next = b_neg_next ? {b_int, {FRAC_W{1'b0}}} - {6'd0, la_frac}
                                   : {b_int, la_frac};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= la_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_neg_reg  <= b_neg_next;
            b_abs_reg  <= b_abs_next;
            b_side_reg <= la_side;
        end
    end

    // ---------------- stage c: t = beta * log2(E/Ec)
    logic        c_vld_reg;
    logic        c_neg_reg;
    logic [33:0] c_mag_reg;
    sa_t         c_side_reg;
    logic [49:0] c_prod;

    assign c_prod = 50'(b_abs_reg) * 50'(beta_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_neg_reg  <= b_neg_reg;
            c_mag_reg  <= c_prod[49:16];
            c_side_reg <= b_side_reg;
        end
    end

    // ---------------- stage d: floor and fraction of t, range class
    logic              d_vld_reg;
    logic [FRAC_W-1:0] d_f_reg;
    sb_t               d_side_reg;
    logic [9:0]        d_ip;
    logic [FRAC_W-1:0] d_fr;
    logic [10:0]       d_nmag;
    exp_cls_t          d_cls;
    sb_t               d_side_next;
    logic [FRAC_W-1:0] d_f_next;

    assign d_ip   = c_mag_reg[33:24];
    assign d_fr   = c_mag_reg[23:0];
    assign d_nmag = 11'(d_ip) + 11'(d_fr != '0);

    always_comb begin
        if (!c_neg_reg && d_ip >= 10'd31) begin
            d_cls = CLS_BIG;
        end else if (c_neg_reg && d_nmag > 11'd32) begin
            d_cls = CLS_SMALL;
        end else begin
            d_cls = CLS_MID;
        end
        d_f_next         = c_neg_reg ? FRAC_W'(0) - d_fr : d_fr;
        d_side_next.e    = c_side_reg.e;
        d_side_next.zero = c_side_reg.zero;
        d_side_next.cls  = d_cls;
        // shift that places 2^frac (Q1.30) into Q.32
        d_side_next.d    = c_neg_reg ? 7'd2 - 7'(d_nmag) : 7'(d_ip) + 7'd2;
        d_side_next.mag  = c_mag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_f_reg    <= d_f_next;
            d_side_reg <= d_side_next;
        end
    end

    logic              ea_vld;
    logic [MANT_W-1:0] ea_g;
    sb_t               ea_side;

    fdm_exp2 #(.SIDE_W($bits(sb_t))) u_exp2_pow (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (d_vld_reg),
        .in_f     (d_f_reg),
        .in_side  (d_side_reg),
        .out_vld  (ea_vld),
        .out_g    (ea_g),
        .out_side (ea_side)
    );

    // ---------------- stage e: s = 1 + (E/Ec)^beta in Q.32
    logic        e_vld_reg;
    logic [63:0] e_s_reg;
    sc_t         e_side_reg;
    logic [6:0]  e_rsh;
    logic [63:0] e_u;
    sc_t         e_side_next;

    assign e_rsh = 7'd0 - ea_side.d;
    assign e_u   = ea_side.d[6] ? ({32'd0, ea_g} >> e_rsh[5:0])
                                : ({32'd0, ea_g} << ea_side.d[5:0]);

    always_comb begin
        e_side_next.e    = ea_side.e;
        e_side_next.zero = ea_side.zero;
        e_side_next.cls  = ea_side.cls;
        e_side_next.mag  = ea_side.mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg <= ea_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_s_reg    <= 64'h1_0000_0000 + e_u;
            e_side_reg <= e_side_next;
        end
    end

    logic              lb_vld;
    logic [5:0]        lb_p;
    logic [FRAC_W-1:0] lb_frac;
    sc_t               lb_side;

    fdm_log2 #(.IN_W(64), .SIDE_W($bits(sc_t))) u_log2_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (e_vld_reg),
        .in_x     (e_s_reg),
        .in_side  (e_side_reg),
        .out_vld  (lb_vld),
        .out_p    (lb_p),
        .out_frac (lb_frac),
        .out_side (lb_side)
    );

    // ---------------- stage f: ls = log2(s), with the large and small cases
    logic        f_vld_reg;
    logic [33:0] f_ls_reg;
    sa_t         f_side_reg;
    logic [33:0] f_ls_next;
    logic [5:0]  f_int;

    assign f_int = lb_p - 6'd32;

    always_comb begin
        case (lb_side.cls)
            CLS_BIG:   f_ls_next = lb_side.mag;
            CLS_SMALL: f_ls_next = '0;
            default:   f_ls_next = {5'd0, f_int[4:0], lb_frac};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= lb_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_ls_reg        <= f_ls_next;
            f_side_reg.e    <= lb_side.e;
            f_side_reg.zero <= lb_side.zero;
        end
    end

    // ---------------- stage g: v = ls / beta
    logic        g_vld_reg;
    logic [37:0] g_v_reg;
    sa_t         g_side_reg;
    logic [53:0] g_prod;

    assign g_prod = 54'(f_ls_reg) * 54'(beta_recip_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
        end else if (en) begin
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_v_reg    <= g_prod[53:16];
            g_side_reg <= f_side_reg;
        end
    end

    // ---------------- stage h: 2^-v = 2^(1-frac) * 2^-(int+1)
    logic              h_vld_reg;
    logic [FRAC_W-1:0] h_f_reg;
    sd_t               h_side_reg;
    logic [FRAC_W-1:0] h_fr;
    logic [14:0]       h_k;
    sd_t               h_side_next;

    assign h_fr = g_v_reg[23:0];
    assign h_k  = 15'(g_v_reg[37:24]) + 15'(h_fr != '0);

    always_comb begin
        h_side_next.e    = g_side_reg.e;
        h_side_next.zero = g_side_reg.zero;
        h_side_next.kbig = h_k >= 15'd33;
        h_side_next.ksh  = h_k[5:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_vld_reg <= 1'b0;
        end else if (en) begin
            h_vld_reg <= g_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // a zero fraction gives 2^0 = 1 from the exp2 unit as well
            h_f_reg    <= FRAC_W'(0) - h_fr;
            h_side_reg <= h_side_next;
        end
    end

    logic              eb_vld;
    logic [MANT_W-1:0] eb_g;
    sd_t               eb_side;

    fdm_exp2 #(.SIDE_W($bits(sd_t))) u_exp2_atten (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (h_vld_reg),
        .in_f     (h_f_reg),
        .in_side  (h_side_reg),
        .out_vld  (eb_vld),
        .out_g    (eb_g),
        .out_side (eb_side)
    );

    // ---------------- stage i: mu_low * 2^(1-frac)
    logic        i_vld_reg;
    logic [51:0] i_prod_reg;
    sd_t         i_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_vld_reg <= 1'b0;
        end else if (en) begin
            i_vld_reg <= eb_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            i_prod_reg <= 52'(low_mob_reg) * 52'(eb_g);
            i_side_reg <= eb_side;
        end
    end

    // ---------------- stage j: rounding shift to Q12.8
    logic               j_vld_reg;
    logic [MOB_W-1:0]   j_mu_reg;
    logic [FIELD_W-1:0] j_e_reg;
    logic [5:0]         j_sh;
    logic [22:0]        j_rnd;
    logic [22:0]        j_full;
    logic [MOB_W-1:0]   j_mu_next;

    assign j_sh   = 6'd29 + i_side_reg.ksh;
    assign j_rnd  = 23'(i_prod_reg >> j_sh);
    assign j_full = {1'b0, j_rnd[22:1]} + 23'(j_rnd[0]);

    always_comb begin
        if (i_side_reg.zero) begin
            j_mu_next = low_mob_reg;
        end else if (i_side_reg.kbig) begin
            j_mu_next = '0;
        end else if (j_full > 23'(MOB_MAX)) begin
            j_mu_next = MOB_MAX;
        end else begin
            j_mu_next = j_full[MOB_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_vld_reg <= 1'b0;
        end else if (en) begin
            j_vld_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            j_mu_reg <= j_mu_next;
            j_e_reg  <= i_side_reg.e;
        end
    end

    // ---------------- stage k: mu * E and thickness scaling
    logic             k_vld_reg;
    logic [39:0]      k_den_reg;
    logic [32:0]      k_num_reg;
    logic [MOB_W-1:0] k_mu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_vld_reg <= 1'b0;
        end else if (en) begin
            k_vld_reg <= j_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_den_reg <= 40'(j_mu_reg) * 40'(j_e_reg);
            k_num_reg <= 33'(thick_reg) * 33'(UM_TO_NS_SCALE);
            k_mu_reg  <= j_mu_reg;
        end
    end

    // ---------------- stage l: rounded dividend and overflow check
    logic        l_vld_reg;
    logic [49:0] l_num_reg;
    logic [39:0] l_den_reg;
    se_t         l_side_reg;
    logic [49:0] l_num_next;
    logic        l_sat_next;

    assign l_num_next = {1'b0, k_num_reg, 16'd0} + 50'(k_den_reg >> 1);
    assign l_sat_next = (k_den_reg == '0) || ({14'd0, l_num_next} >= {k_den_reg, 24'd0});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_vld_reg <= 1'b0;
        end else if (en) begin
            l_vld_reg <= k_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            l_num_reg      <= l_num_next;
            l_den_reg      <= k_den_reg;
            l_side_reg.mu  <= k_mu_reg;
            l_side_reg.sat <= l_sat_next;
        end
    end

    logic              dv_vld;
    logic [TIME_W-1:0] dv_q;
    se_t               dv_side;

    fdm_div #(.SIDE_W($bits(se_t))) u_div_time (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (l_vld_reg),
        .in_num   (l_num_reg),
        .in_den   (l_den_reg),
        .in_side  (l_side_reg),
        .out_vld  (dv_vld),
        .out_q    (dv_q),
        .out_side (dv_side)
    );

    // ---------------- output register
    logic              m_valid_reg;
    logic [MOB_W-1:0]  m_mob_reg;
    logic [TIME_W-1:0] m_time_reg;
    logic              m_sat_reg;

    assign en = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_mob_reg  <= dv_side.mu;
            m_time_reg <= dv_side.sat ? TIME_MAX : dv_q;
            m_sat_reg  <= dv_side.sat;
        end
    end

    assign s_ready          = en;
    assign m_valid          = m_valid_reg;
    assign m_mobility       = m_mob_reg;
    assign m_drift_time     = m_time_reg;
    assign m_time_saturated = m_sat_reg;

    // a saturated item always carries the maximum time
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_sat_reg |-> m_time_reg == TIME_MAX)
        else $error("saturated item without maximum drift time");

    // a finite drift time needs a nonzero mobility
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_sat_reg |-> m_mob_reg != '0)
        else $error("finite drift time with zero mobility");

    // the pipeline never moves while a result is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(dv_vld))
        else $error("pipeline advanced during output stall");

endmodule

// File: hw/rtl/fdm_log2.sv
// pipelined log2: leading-one search, normalize, one squaring per stage
module fdm_log2 #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic [IN_W-1:0]          in_x,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_vld,
    output logic [$clog2(IN_W)-1:0]  out_p,
    output logic [fdm_pkg::FRAC_W-1:0] out_frac,
    output logic [SIDE_W-1:0]        out_side
);
    import fdm_pkg::*;

    localparam int P_W = $clog2(IN_W);
    localparam int NST = FRAC_W + 2;

    logic [NST:0]             vld_reg;
    logic [SIDE_W-1:0]        side_reg [0:NST];
    logic [P_W-1:0]           p_reg    [0:NST];
    logic [IN_W-1:0]          x_reg;
    logic [MANT_W-1:0]        m_reg    [1:NST];
    logic [FRAC_W-1:0]        frac_reg [1:NST];

    logic [P_W-1:0]           p_next;
    logic [P_W:0]             lsh;
    logic [IN_W-1:0]          xn;

    assign vld_reg[0]  = in_vld;
    assign side_reg[0] = in_side;
    assign p_reg[0]    = p_next;

    always_comb begin
        p_next = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (in_x[i]) begin
                p_next = P_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[NST:1] <= '0;
        end else if (en) begin
            vld_reg[NST:1] <= vld_reg[NST-1:0];
        end
    end

    // stage 1: leading-one position
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg       <= in_x;
            p_reg[1]    <= p_next;
            side_reg[1] <= side_reg[0];
        end
    end

    // stage 2: normalize so the leading one sits at mantissa bit 31
    assign lsh = (P_W+1)'(IN_W - 1) - {1'b0, p_reg[1]};
    assign xn  = x_reg << lsh;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[2]    <= xn[IN_W-1 -: MANT_W];
            frac_reg[2] <= '0;
            p_reg[2]    <= p_reg[1];
            side_reg[2] <= side_reg[1];
        end
    end

    assign m_reg[1]    = '0;
    assign frac_reg[1] = '0;

    // one fraction bit per squaring
    for (genvar i = 0; i < FRAC_W; i++) begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     sh;
        logic [MANT_W-1:0]   m_next;
        logic [FRAC_W-1:0]   frac_next;

        assign sq = {{MANT_W{1'b0}}, m_reg[i+2]} * {{MANT_W{1'b0}}, m_reg[i+2]};
        assign sh = sq[2*MANT_W-1 -: MANT_W+1];

        always_comb begin
            frac_next = frac_reg[i+2];
            if (sh[MANT_W]) begin
                m_next = sh[MANT_W:1];
                frac_next[FRAC_W-1-i] = 1'b1;
            end else begin
                m_next = sh[MANT_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[i+3]    <= m_next;
                frac_reg[i+3] <= frac_next;
                p_reg[i+3]    <= p_reg[i+2];
                side_reg[i+3] <= side_reg[i+2];
            end
        end
    end

    assign out_vld  = vld_reg[NST];
    assign out_p    = p_reg[NST];
    assign out_frac = frac_reg[NST];
    assign out_side = side_reg[NST];

endmodule

// File: hw/rtl/fdm_exp2.sv
// pipelined 2^f for a fraction f, one table factor per stage
module fdm_exp2 #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [fdm_pkg::FRAC_W-1:0]  in_f,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_vld,
    output logic [fdm_pkg::MANT_W-1:0]  out_g,
    output logic [SIDE_W-1:0]           out_side
);
    import fdm_pkg::*;

    logic [FRAC_W:0]      vld_reg;
    logic [SIDE_W-1:0]    side_reg [0:FRAC_W];
    logic [FRAC_W-1:0]    f_reg    [0:FRAC_W];
    logic [MANT_W-1:0]    g_reg    [0:FRAC_W];

    assign vld_reg[0]  = in_vld;
    assign side_reg[0] = in_side;
    assign f_reg[0]    = in_f;
    assign g_reg[0]    = MANT_W'(1) << 30;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[FRAC_W:1] <= '0;
        end else if (en) begin
            vld_reg[FRAC_W:1] <= vld_reg[FRAC_W-1:0];
        end
    end

    for (genvar k = 1; k <= FRAC_W; k++) begin : g_step
        logic [2*MANT_W-1:0] prod;
        logic [2*MANT_W-1:0] rnd;
        logic [MANT_W-1:0]   g_next;

        // product rounded half up at 2^-30
        assign prod   = {{MANT_W{1'b0}}, g_reg[k-1]} * {{MANT_W{1'b0}}, EXP2_ROM[k]};
        assign rnd    = prod + (64'd1 << 29);
        assign g_next = f_reg[k-1][FRAC_W-k] ? rnd[30 +: MANT_W] : g_reg[k-1];

        always_ff @(posedge aclk) begin
            if (en) begin
                g_reg[k]    <= g_next;
                f_reg[k]    <= f_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[FRAC_W];
    assign out_g    = g_reg[FRAC_W];
    assign out_side = side_reg[FRAC_W];

endmodule

// File: hw/rtl/fdm_div.sv
// pipelined restoring divider, one quotient bit per stage
module fdm_div #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [49:0]                 in_num,
    input  logic [39:0]                 in_den,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_vld,
    output logic [fdm_pkg::TIME_W-1:0]  out_q,
    output logic [SIDE_W-1:0]           out_side
);
    import fdm_pkg::*;

    logic [TIME_W:0]      vld_reg;
    logic [SIDE_W-1:0]    side_reg [0:TIME_W];
    logic [49:0]          rem_reg  [0:TIME_W];
    logic [39:0]          den_reg  [0:TIME_W];
    logic [TIME_W-1:0]    q_reg    [0:TIME_W];

    assign vld_reg[0]  = in_vld;
    assign side_reg[0] = in_side;
    assign rem_reg[0]  = in_num;
    assign den_reg[0]  = in_den;
    assign q_reg[0]    = '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[TIME_W:1] <= '0;
        end else if (en) begin
            vld_reg[TIME_W:1] <= vld_reg[TIME_W-1:0];
        end
    end

    for (genvar j = 0; j < TIME_W; j++) begin : g_bit
        localparam int B = TIME_W - 1 - j;
        logic [63:0]       trial;
        logic [63:0]       rem_w;
        logic              take;
        logic [49:0]       rem_next;
        logic [TIME_W-1:0] q_next;

        assign trial = {24'd0, den_reg[j]} << B;
        assign rem_w = {14'd0, rem_reg[j]};
        assign take  = rem_w >= trial;

        always_comb begin
            rem_next = rem_reg[j];
            q_next   = q_reg[j];
            if (take) begin
                rem_next  = 50'(rem_w - trial);
                q_next[B] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= rem_next;
                q_reg[j+1]    <= q_next;
                den_reg[j+1]  <= den_reg[j];
                side_reg[j+1] <= side_reg[j];
            end
        end
    end

    assign out_vld  = vld_reg[TIME_W];
    assign out_q    = q_reg[TIME_W];
    assign out_side = side_reg[TIME_W];

endmodule
